### rtl/yuv444_to_dual_yuv420_splitter_assert.svh
// Assertion macros for the 4:4:4 to dual 4:2:0 splitter checker.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef YUV444_TO_DUAL_YUV420_SPLITTER_ASSERT_SVH
`define YUV444_TO_DUAL_YUV420_SPLITTER_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define YS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset.
`define YS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// What must hold the cycle after a reset edge.
`define YS_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

### rtl/ysplit_pkg.sv
// Shared types and constants of the 4:4:4 to dual 4:2:0 splitter.
// No dependencies.
`timescale 1ns / 1ps

package ysplit_pkg;

  localparam int CFG_W        = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int SAMPLE_W     = 8;
  localparam int COORD_W      = 12;
  localparam int JOB_DEPTH    = 2;
  localparam int RES_DEPTH    = 2;

  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_HEIGHT   = 4096;
  localparam int DEF_FRAME_WIDTH  = 1920;
  localparam int DEF_FRAME_HEIGHT = 1080;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic       VIEW_MAIN = 1'b0;
  localparam logic       VIEW_AUX  = 1'b1;
  localparam logic [1:0] PLANE_Y   = 2'd0;
  localparam logic [1:0] PLANE_U   = 2'd1;
  localparam logic [1:0] PLANE_V   = 2'd2;

  // Which write group a pixel feeds besides its main luma write.
  typedef enum logic [1:0] {
    KIND_MAIN_CHROMA,
    KIND_AUX_LUMA,
    KIND_AUX_CHROMA
  } kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] cb;
    logic [SAMPLE_W-1:0] cr;
  } pix_t;

  typedef struct packed {
    logic                view;
    logic [1:0]          plane;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } res_t;

endpackage

### rtl/ysplit_fifo.sv
// Small register FIFO used for the job queue and the result queue.
// Depends on nothing.
`timescale 1ns / 1ps

module ysplit_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### rtl/ysplit_front.sv
// Front end: tracks column and row of incoming pixels and classifies them.
// Depends on ysplit_pkg.
`timescale 1ns / 1ps

module ysplit_front
  import ysplit_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          job_full,
  input  logic          frame_start,
  input  pix_t          pix,
  input  logic [WW-1:0] eff_w,
  input  logic [HW-1:0] eff_h,
  output logic          job_push,
  output logic [XW-1:0] job_x,
  output logic [YW-1:0] job_y,
  output kind_t         job_kind,
  output pix_t          job_pix
);

  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [WW-1:0] c0, cn;
  logic [HW-1:0] r0, r1, rn;
  logic [XW-1:0] x;
  logic [YW-1:0] y;

  always_comb begin
    c0 = frame_start ? '0 : WW'(col_r);
    r0 = frame_start ? '0 : HW'(row_r);
    r1 = r0;
    // counter left past a shrunken line: move to start of next row
    if (c0 >= eff_w) begin
      c0 = '0;
      r1 = r0 + 1'b1;
    end
    if (r1 >= eff_h) begin
      r1 = '0;
    end
    x = XW'(c0);
    y = YW'(r1);

    cn = WW'(x) + 1'b1;
    rn = HW'(y) + 1'b1;
    if (cn >= eff_w) begin
      col_nxt = '0;
      row_nxt = (rn >= eff_h) ? '0 : YW'(rn);
    end else begin
      col_nxt = XW'(cn);
      row_nxt = y;
    end
  end

  assign job_push = push && !job_full;
  assign job_x    = x;
  assign job_y    = y;
  assign job_pix  = pix;

  always_comb begin
    if (x[0]) begin
      job_kind = KIND_AUX_LUMA;
    end else if (!y[0]) begin
      job_kind = KIND_MAIN_CHROMA;
    end else begin
      job_kind = KIND_AUX_CHROMA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (job_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### rtl/ysplit_back.sv
// Back end: turns one queued pixel job into one to three plane writes.
// Depends on ysplit_pkg.
`timescale 1ns / 1ps

module ysplit_back
  import ysplit_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  logic [XW-1:0] job_x,
  input  logic [YW-1:0] job_y,
  input  kind_t         job_kind,
  input  pix_t          job_pix,
  input  logic [WW-1:0] eff_w,
  input  logic [HW-1:0] eff_h,
  output logic          job_pop,
  input  logic          res_full,
  output logic          res_push,
  output res_t          res
);

  logic [1:0]    step_r, step_nxt;
  logic [1:0]    num_res;
  logic [WW-1:0] half_w, quarter_w, xh, q;
  logic [HW-1:0] half_h, yh;
  logic          main_ok, aux_ok, aux_second_ok, last;
  logic [1:0]    aux_plane;

  assign half_w    = eff_w >> 1;
  assign quarter_w = eff_w >> 2;
  assign half_h    = eff_h >> 1;
  assign xh        = WW'(job_x >> 1);
  assign q         = WW'(job_x >> 2);
  assign yh        = HW'(job_y >> 1);

  assign main_ok       = (xh < half_w) && (yh < half_h);
  assign aux_ok        = (q < quarter_w) && (yh < half_h);
  assign aux_second_ok = (quarter_w + q) < half_w;
  // columns 4k feed aux U, columns 4k+2 feed aux V
  assign aux_plane     = job_x[1] ? PLANE_V : PLANE_U;

  always_comb begin
    case (job_kind)
      KIND_MAIN_CHROMA: num_res = main_ok ? 2'd3 : 2'd1;
      KIND_AUX_LUMA:    num_res = 2'd3;
      KIND_AUX_CHROMA:  num_res = aux_ok ? (aux_second_ok ? 2'd3 : 2'd2) : 2'd1;
      default:          num_res = 2'd1;
    endcase
  end

  assign last = (step_r == num_res - 2'd1);

  always_comb begin
    res.last = last;
    case (step_r)
      2'd1: begin
        res.value = job_pix.cb;
        case (job_kind)
          KIND_MAIN_CHROMA: begin
            res.view = VIEW_MAIN;
            res.plane = PLANE_U;
            res.col = COORD_W'(xh);
            res.row = COORD_W'(yh);
          end
          KIND_AUX_LUMA: begin
            res.view = VIEW_AUX;
            res.plane = PLANE_Y;
            res.col = COORD_W'(xh);
            res.row = COORD_W'(job_y);
          end
          default: begin
            res.view = VIEW_AUX;
            res.plane = aux_plane;
            res.col = COORD_W'(q);
            res.row = COORD_W'(yh);
          end
        endcase
      end
      2'd2: begin
        res.value = job_pix.cr;
        case (job_kind)
          KIND_MAIN_CHROMA: begin
            res.view = VIEW_MAIN;
            res.plane = PLANE_V;
            res.col = COORD_W'(xh);
            res.row = COORD_W'(yh);
          end
          KIND_AUX_LUMA: begin
            res.view = VIEW_AUX;
            res.plane = PLANE_Y;
            res.col = COORD_W'(half_w + xh);
            res.row = COORD_W'(job_y);
          end
          default: begin
            res.view = VIEW_AUX;
            res.plane = aux_plane;
            res.col = COORD_W'(quarter_w + q);
            res.row = COORD_W'(yh);
          end
        endcase
      end
      default: begin
        res.value = job_pix.luma;
        res.view = VIEW_MAIN;
        res.plane = PLANE_Y;
        res.col = COORD_W'(job_x);
        res.row = COORD_W'(job_y);
      end
    endcase
  end

  assign res_push = job_valid && !res_full;
  assign job_pop  = res_push && last;
  assign step_nxt = job_pop ? 2'd0 : step_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
    end else if (res_push) begin
      step_r <= step_nxt;
    end
  end

endmodule

### rtl/yuv444_to_dual_yuv420_splitter.sv
// Channel | ports                         | word
// --------+-------------------------------+-----------------------------------------
// input   | in_push / in_full             | frame_start, Y, U, V of one 4:4:4 pixel
// result  | out_pop / out_empty           | view, plane, column, row, sample, last
// config  | cfg_valid / cfg_ready         | register index and data, always ready
//
// A pixel yields 1 to 3 words (3 for most pixels), one per cycle from the back-end
// emitter while the result queue has room; the emitter sets the rate.
// Input takes a word every cycle while the two-deep job queue has room.
// A two-deep result queue keeps the emitter running while out_pop is low, until it fills.
// Synchronous reset clears counters and queues and restores 1920 x 1080.
// Depends on ysplit_pkg, ysplit_fifo, ysplit_front, ysplit_back.
`timescale 1ns / 1ps

module yuv444_to_dual_yuv420_splitter
  import ysplit_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic                   in_frame_start,
  input  logic [SAMPLE_W-1:0]    in_luma_in,
  input  logic [SAMPLE_W-1:0]    in_cb_in,
  input  logic [SAMPLE_W-1:0]    in_cr_in,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic                   out_view,
  output logic [1:0]             out_plane,
  output logic [COORD_W-1:0]     out_dest_column,
  output logic [COORD_W-1:0]     out_dest_row,
  output logic [SAMPLE_W-1:0]    out_sample_value,
  output logic                   out_last_of_pixel,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (DEF_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_FRAME_WIDTH;
  localparam int RST_H = (DEF_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEF_FRAME_HEIGHT;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    kind_t         kind;
    pix_t          pix;
  } job_t;

  // registers hold the clamped size: 0 reads as 1, oversize as the maximum
  logic [WW-1:0] eff_w_r;
  logic [HW-1:0] eff_h_r;
  logic          cfg_wr;

  job_t  job_in, job_out;
  pix_t  in_pix;
  logic  job_push, job_full, job_empty, job_pop;
  logic  res_push, res_full;
  res_t  res_in, res_out;
  kind_t front_kind;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(RST_W);
      eff_h_r <= HW'(RST_H);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_data == '0) begin
            eff_w_r <= WW'(1);
          end else if ({1'b0, cfg_data} > (CFG_W + 1)'(MAX_WIDTH)) begin
            eff_w_r <= WW'(MAX_WIDTH);
          end else begin
            eff_w_r <= WW'(cfg_data);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_data == '0) begin
            eff_h_r <= HW'(1);
          end else if ({1'b0, cfg_data} > (CFG_W + 1)'(MAX_HEIGHT)) begin
            eff_h_r <= HW'(MAX_HEIGHT);
          end else begin
            eff_h_r <= HW'(cfg_data);
          end
        end
        default: ;
      endcase
    end
  end

  assign in_pix = '{luma: in_luma_in, cb: in_cb_in, cr: in_cr_in};

  ysplit_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .job_full    (job_full),
    .frame_start (in_frame_start),
    .pix         (in_pix),
    .eff_w       (eff_w_r),
    .eff_h       (eff_h_r),
    .job_push    (job_push),
    .job_x       (job_in.x),
    .job_y       (job_in.y),
    .job_kind    (front_kind),
    .job_pix     (job_in.pix)
  );

  assign job_in.kind = front_kind;
  assign in_full     = job_full;

  ysplit_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  ysplit_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job_x     (job_out.x),
    .job_y     (job_out.y),
    .job_kind  (job_out.kind),
    .job_pix   (job_out.pix),
    .eff_w     (eff_w_r),
    .eff_h     (eff_h_r),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ysplit_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_view          = res_out.view;
  assign out_plane         = res_out.plane;
  assign out_dest_column   = res_out.col;
  assign out_dest_row      = res_out.row;
  assign out_sample_value  = res_out.value;
  assign out_last_of_pixel = res_out.last;

endmodule

### rtl/ysplit_checker.sv
// Port-level checks of the splitter, bound to the top level.
// Depends on ysplit_pkg and yuv444_to_dual_yuv420_splitter_assert.svh.
`timescale 1ns / 1ps
`include "yuv444_to_dual_yuv420_splitter_assert.svh"

module ysplit_checker
  import ysplit_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input logic                out_view,
  input logic [1:0]          out_plane,
  input logic [COORD_W-1:0]  out_dest_column,
  input logic [COORD_W-1:0]  out_dest_row,
  input logic [SAMPLE_W-1:0] out_sample_value,
  input logic                out_last_of_pixel
);

  logic [$bits(res_t)-1:0] out_word;
  logic                    out_stall;
  logic                    plane_known;
  logic                    main_u_shown;

  assign out_word     = {out_view, out_plane, out_dest_column, out_dest_row, out_sample_value,
                         out_last_of_pixel};
  assign out_stall    = !out_empty && !out_pop;
  assign plane_known  = (out_plane == PLANE_Y) || (out_plane == PLANE_U) ||
                        (out_plane == PLANE_V);
  assign main_u_shown = !out_empty && (out_view == VIEW_MAIN) && (out_plane == PLANE_U);

  // a waiting word stays put until taken
  `YS_ASSERT_NEXT(a_out_hold, out_stall, !out_empty && $stable(out_word), "stalled word changed")

  `YS_ASSERT_NOW(a_plane_code, !out_empty, plane_known, "invalid plane code")

  // main U is always followed by main V of the same pixel
  `YS_ASSERT_NOW(a_main_u_not_last, main_u_shown, !out_last_of_pixel, "main U marked last")

  `YS_ASSERT_RST(a_reset_clear, out_empty && !in_full, "queues not clear after reset")

endmodule

bind yuv444_to_dual_yuv420_splitter ysplit_checker u_ysplit_checker (.*);

### tb/sv/ysplit_tb_pkg.sv
// Write predictor and checker for the 4:4:4 to dual 4:2:0 splitter testbench.
// Depends on ysplit_pkg for the result word layout and the register indexes.
`timescale 1ns / 1ps

package ysplit_tb_pkg;
  import ysplit_pkg::*;

  class plane_write_checker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    res_t             pending_writes[$];
    int unsigned      mismatches;
    int unsigned      words_seen;
    int unsigned      pixels_seen;
    // main Y, main chroma, aux luma, aux chroma
    int unsigned      words_by_target[4];

    function new();
      width_reg   = CFG_W'(DEF_FRAME_WIDTH);
      height_reg  = CFG_W'(DEF_FRAME_HEIGHT);
      col_cnt     = 0;
      row_cnt     = 0;
      mismatches  = 0;
      words_seen  = 0;
      pixels_seen = 0;
      foreach (words_by_target[i]) words_by_target[i] = 0;
    endfunction

    function int unsigned active_size(logic [CFG_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return 32'(v);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_FRAME_WIDTH:  width_reg = data;
        REG_FRAME_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function void queue_write(logic view, logic [1:0] plane, int unsigned c, int unsigned r,
                              logic [SAMPLE_W-1:0] val);
      res_t w;
      w.view  = view;
      w.plane = plane;
      w.col   = c[COORD_W-1:0];
      w.row   = r[COORD_W-1:0];
      w.value = val;
      w.last  = 1'b0;
      pending_writes.push_back(w);
    endfunction

    function void note_pixel(logic fs, logic [SAMPLE_W-1:0] y_s, logic [SAMPLE_W-1:0] cb_s,
                             logic [SAMPLE_W-1:0] cr_s);
      int unsigned w, h, x, y, half_w, quarter_w, half_h, q;
      logic [1:0]  aux_plane;
      w = active_size(width_reg, DEF_MAX_WIDTH);
      h = active_size(height_reg, DEF_MAX_HEIGHT);
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      // counters may sit past a frame that was shrunk between words
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      x = col_cnt;
      y = row_cnt;
      half_w = w / 2;
      quarter_w = w / 4;
      half_h = h / 2;

      queue_write(VIEW_MAIN, PLANE_Y, x, y, y_s);
      if (x[0] == 1'b0 && y[0] == 1'b0) begin
        if (x / 2 < half_w && y / 2 < half_h) begin
          queue_write(VIEW_MAIN, PLANE_U, x / 2, y / 2, cb_s);
          queue_write(VIEW_MAIN, PLANE_V, x / 2, y / 2, cr_s);
        end
      end else if (x[0] == 1'b1) begin
        queue_write(VIEW_AUX, PLANE_Y, x / 2, y, cb_s);
        queue_write(VIEW_AUX, PLANE_Y, half_w + x / 2, y, cr_s);
      end else begin
        aux_plane = (x[1:0] == 2'd0) ? PLANE_U : PLANE_V;
        q = x / 4;
        if (q < quarter_w && y / 2 < half_h) begin
          queue_write(VIEW_AUX, aux_plane, q, y / 2, cb_s);
          if (quarter_w + q < half_w)
            queue_write(VIEW_AUX, aux_plane, quarter_w + q, y / 2, cr_s);
        end
      end
      pending_writes[pending_writes.size() - 1].last = 1'b1;

      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h) row_cnt = 0;
      end
      pixels_seen++;
    endfunction

    function void check_word(res_t got);
      res_t want;
      words_seen++;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word view=%0d plane=%0d col=%0d row=%0d val=%0d last=%0d",
                   got.view, got.plane, got.col, got.row, got.value, got.last);
        return;
      end
      want = pending_writes.pop_front();
      words_by_target[{want.view, want.plane != PLANE_Y}]++;
      if (got.view !== want.view || got.plane !== want.plane || got.col !== want.col ||
          got.row !== want.row || got.value !== want.value || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: word %0d exp view=%0d plane=%0d col=%0d row=%0d val=%0d last=%0d",
                   words_seen, want.view, want.plane, want.col, want.row, want.value, want.last);
          $display("ERROR: word %0d got view=%0d plane=%0d col=%0d row=%0d val=%0d last=%0d",
                   words_seen, got.view, got.plane, got.col, got.row, got.value, got.last);
        end
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
// Top of the splitter testbench: clock, reset, pixel and register drivers, word receiver.
// Depends on ysplit_pkg, ysplit_tb_pkg and the yuv444_to_dual_yuv420_splitter RTL.
`timescale 1ns / 1ps

module tb_top;
  import ysplit_pkg::*;
  import ysplit_tb_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 9;
  localparam int PIXELS_PER_PHASE = 50;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  logic                   in_frame_start = 1'b0;
  logic [SAMPLE_W-1:0]    in_luma_in = '0;
  logic [SAMPLE_W-1:0]    in_cb_in = '0;
  logic [SAMPLE_W-1:0]    in_cr_in = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic                   out_view;
  logic [1:0]             out_plane;
  logic [COORD_W-1:0]     out_dest_column;
  logic [COORD_W-1:0]     out_dest_row;
  logic [SAMPLE_W-1:0]    out_sample_value;
  logic                   out_last_of_pixel;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int send_idle_pct = 21;
  int recv_idle_pct = 87;
  int rx_hold_cycles = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int geometries = 0;

  plane_write_checker writes_model = new();

  yuv444_to_dual_yuv420_splitter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_frame_start    (in_frame_start),
    .in_luma_in        (in_luma_in),
    .in_cb_in          (in_cb_in),
    .in_cr_in          (in_cr_in),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_view          (out_view),
    .out_plane         (out_plane),
    .out_dest_column   (out_dest_column),
    .out_dest_row      (out_dest_row),
    .out_sample_value  (out_sample_value),
    .out_last_of_pixel (out_last_of_pixel),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               writes_model.pending_writes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Word receiver: checks what it takes, then picks pop for the next cycle.
  always @(posedge clk) begin : receive_words
    res_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.view  = out_view;
      got.plane = out_plane;
      got.col   = out_dest_column;
      got.row   = out_dest_row;
      got.value = out_sample_value;
      got.last  = out_last_of_pixel;
      writes_model.check_word(got);
    end
    if (rx_hold_cycles > 0) begin
      hold_left = rx_hold_cycles;
      rx_hold_cycles = 0;
    end
    if (!rst_n || hold_left > 0) begin
      out_pop <= 1'b0;
      if (hold_left > 0) hold_left--;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_pixel(input logic fs, input logic [SAMPLE_W-1:0] y_s,
                            input logic [SAMPLE_W-1:0] cb_s, input logic [SAMPLE_W-1:0] cr_s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_frame_start <= fs;
    in_luma_in     <= y_s;
    in_cb_in       <= cb_s;
    in_cr_in       <= cr_s;
    do @(posedge clk); while (in_full);
    writes_model.note_pixel(fs, y_s, cb_s, cr_s);
  endtask

  // Stops the pixel stream and waits for every predicted word to come out.
  task automatic wait_all_written();
    in_push <= 1'b0;
    while (writes_model.pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic program_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input bit junk);
    logic [CFG_INDEX_W-1:0] idx[3];
    logic [CFG_W-1:0]       val[3];
    int                     n;
    idx[0] = REG_FRAME_WIDTH;
    val[0] = w;
    idx[1] = REG_FRAME_HEIGHT;
    val[1] = h;
    idx[2] = REG_UNMAPPED;
    val[2] = CFG_W'($urandom);
    n = junk ? 3 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      writes_model.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    geometries++;
  endtask

  initial begin
    logic [CFG_W-1:0] fw, fh;
    int               frame_px;
    logic             fs;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default geometry, extremes of the samples
    push_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    push_pixel(1'b0, 8'hff, 8'hff, 8'hff);
    // zero size acts as 1 x 1: only the main luma write survives
    wait_all_written();
    program_size('0, '0, 1'b0);
    push_pixel(1'b0, 8'h5a, 8'ha5, 8'h3c);
    push_pixel(1'b0, 8'hc3, 8'h0f, 8'hf0);
    // oversize clamps to the maximum, unmapped index is ignored
    wait_all_written();
    program_size(13'h1fff, 13'h1fff, 1'b1);
    push_pixel(1'b1, 8'h81, 8'h7e, 8'h18);
    // small odd frame: every write group and every bound within 15 pixels
    wait_all_written();
    program_size(13'd5, 13'd3, 1'b1);
    for (int i = 0; i < 15; i++)
      push_pixel(i == 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 3) ? 21 : (p < 6) ? 87 : 0;
      recv_idle_pct = (p < 3) ? 87 : (p < 6) ? 21 : 0;
      case (p)
        4:       begin fw = 13'd4096; fh = 13'd2; end
        7:       begin fw = 13'd1; fh = 13'd8191; end
        8:       begin fw = 13'd0; fh = 13'($urandom_range(1, 4)); end
        default: begin fw = 13'($urandom_range(2, 12)); fh = 13'($urandom_range(1, 6)); end
      endcase
      wait_all_written();
      program_size(fw, fh, p % 2 == 0);
      frame_px = writes_model.active_size(fw, DEF_MAX_WIDTH) *
                 writes_model.active_size(fh, DEF_MAX_HEIGHT);
      // long receiver stall while pixels keep coming: both queues fill, input backs up
      if (p == 0 || p == 6) rx_hold_cycles = 120;
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        if (p % 3 == 1 && i == PIXELS_PER_PHASE / 2) begin
          // shrink the line mid-frame so the column counter lands past the new width
          wait_all_written();
          program_size(13'($urandom_range(1, 3)), fh, 1'b0);
        end
        fs = (frame_px <= 1000 && i % frame_px == 0) || i == 0 || ($urandom_range(99) < 3);
        push_pixel(fs, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      end
    end

    wait_all_written();
    repeat (20) @(posedge clk);
    $display("Summary: %0d pixels over %0d geometries, %0d words checked",
             writes_model.pixels_seen, geometries, writes_model.words_seen);
    $display("Summary: main Y %0d, main chroma %0d, aux luma %0d, aux chroma %0d, mismatches %0d",
             writes_model.words_by_target[0], writes_model.words_by_target[1],
             writes_model.words_by_target[2], writes_model.words_by_target[3],
             writes_model.mismatches);
    if (writes_model.mismatches == 0 && writes_model.pending_writes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
